### design/snmp_pkg.sv
// ----------------------------------------------------------------------------
// snmp_pkg: shared types and helpers for the serial nibble mouse port
// Holds the operation codes, the packed layout of an input transaction and
// the clamping and nibble-swap helpers used when a motion sample is latched.
// ----------------------------------------------------------------------------
package snmp_pkg;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_ADJUST = 2'd3;

    localparam int          IntervalWidth  = 20;
    localparam logic [19:0] INTERVAL_RESET = 20'd30000;
    localparam logic [31:0] CLAMP_LIMIT    = 32'd127;

    localparam int InDataWidth  = 112;
    localparam int OutDataWidth = 8;

    // Input payload, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]         pad;
        logic               new_clear;
        logic               new_select;
        logic               old_clear;
        logic               frame_en;
        logic [7:0]         button_bits;
        logic signed [15:0] delta_y;
        logic signed [15:0] delta_x;
        logic signed [31:0] time_delta;
        logic signed [31:0] timestamp;
    } in_item_t;

    // Clamp a two's complement 32-bit value to -127..127.
    function automatic logic [31:0] clamp_sample(input logic [31:0] v);
        logic [31:0] lo;
        lo = 32'd0 - CLAMP_LIMIT;
        if (v[31]) begin
            clamp_sample = (v < lo) ? lo : v;
        end else begin
            clamp_sample = (v > CLAMP_LIMIT) ? CLAMP_LIMIT : v;
        end
    endfunction

    // Swap the two nibbles of the low byte.
    function automatic logic [7:0] swap_nibbles(input logic [31:0] v);
        swap_nibbles = {v[3:0], v[7:4]};
    endfunction

endpackage

### design/serial_nibble_mouse_port.sv
// ----------------------------------------------------------------------------
// serial_nibble_mouse_port: mouse port reporting motion as nibbles
// Accumulates host motion, latches clamped samples on clear-line edges and
// answers port reads with one nibble per read transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_) carries one operation per transaction: tuser holds
//   the operation code, tdata the operand fields. Frame updates, line writes
//   and time adjusts only change internal state and produce no output. A read
//   produces exactly one master (m_) transaction holding the port nibble.
//   Every transaction is first captured in an input register and executed
//   once the result register is free, when its state update and any read
//   data are computed and written to the result register. A read thus passes
//   through both registers before m_tvalid, and one transaction can be
//   accepted every cycle unless the receiver stalls a pending result.
//   When the receiver stalls with a result pending, the input register keeps
//   its transaction and s_tready drops once it is full; nothing is lost.
//   latch_interval is written via cfg_wr_en/cfg_wr_data; the user must do so
//   only while idle, as the block does not enforce it. Synchronous active-low
//   reset clears the accumulators, buttons, shifter, line levels and latch
//   time, empties both registers and loads the latch interval with 30000.
// ----------------------------------------------------------------------------
module serial_nibble_mouse_port
    import snmp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [IntervalWidth-1:0] cfg_wr_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // tdata, from bit 0: timestamp[31:0], time_delta[63:32], delta_x[79:64],
    // delta_y[95:80], button_bits[103:96], frame_en[104], old_clear[105],
    // new_select[106], new_clear[107], zero padding[111:108]
    input  logic [InDataWidth-1:0]   s_tdata,
    // tuser, from bit 0: op[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // tdata, from bit 0: read_nibble[3:0], zero padding[7:4]
    output logic [OutDataWidth-1:0]  m_tdata
);

    // Input register.
    logic           in_valid_reg;
    in_item_t       in_item_reg;
    logic [1:0]     in_op_reg;

    // Architectural state.
    logic [IntervalWidth-1:0] latch_interval_reg;
    logic           select_level_reg, select_level_next;
    logic           clear_level_reg, clear_level_next;
    logic [63:0]    last_latch_reg, last_latch_next;
    logic [31:0]    accum_x_reg, accum_x_next;
    logic [31:0]    accum_y_reg, accum_y_next;
    logic [7:0]     buttons_reg, buttons_next;
    logic [15:0]    shifter_reg, shifter_next;

    // Result register.
    logic           m_valid_reg;
    logic [3:0]     m_nibble_reg;

    logic           proc;
    logic [63:0]    now_time;
    logic [63:0]    diff_time;
    logic           fresh;
    logic [31:0]    rx, ry;
    logic [3:0]     read_value;

    // Execute when the result register can take a possible read result.
    assign proc     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_nibble_reg};

    // Latch decision and clamped samples.
    assign now_time  = {{32{in_item_reg.timestamp[31]}}, in_item_reg.timestamp};
    assign diff_time = now_time - last_latch_reg;
    assign fresh     = !diff_time[63] &&
                       (diff_time > {{(64-IntervalWidth){1'b0}}, latch_interval_reg});
    assign rx        = clamp_sample(32'd0 - accum_x_reg);
    assign ry        = clamp_sample(32'd0 - accum_y_reg);
    assign read_value = select_level_reg ? shifter_reg[3:0] : ~buttons_reg[3:0];

    // Next-state logic for the operation in the input register.
    always_comb begin
        select_level_next = select_level_reg;
        clear_level_next  = clear_level_reg;
        last_latch_next   = last_latch_reg;
        accum_x_next      = accum_x_reg;
        accum_y_next      = accum_y_reg;
        buttons_next      = buttons_reg;
        shifter_next      = shifter_reg;
        case (in_op_reg)
            OP_FRAME: begin
                if (in_item_reg.frame_en) begin
                    accum_x_next = accum_x_reg +
                                   {{16{in_item_reg.delta_x[15]}}, in_item_reg.delta_x};
                    accum_y_next = accum_y_reg +
                                   {{16{in_item_reg.delta_y[15]}}, in_item_reg.delta_y};
                    buttons_next = in_item_reg.button_bits;
                end
            end
            OP_WRITE: begin
                if (!in_item_reg.old_clear && in_item_reg.new_clear) begin
                    if (fresh) begin
                        last_latch_next = now_time;
                        shifter_next    = {swap_nibbles(ry), swap_nibbles(rx)};
                        accum_x_next    = accum_x_reg + rx;
                        accum_y_next    = accum_y_reg + ry;
                    end else begin
                        shifter_next = {4'd0, shifter_reg[15:4]};
                    end
                end
                select_level_next = in_item_reg.new_select;
                clear_level_next  = in_item_reg.new_clear;
            end
            OP_ADJUST: begin
                last_latch_next = last_latch_reg +
                                  {{32{in_item_reg.time_delta[31]}}, in_item_reg.time_delta};
            end
            default: begin
            end
        endcase
    end

    // Input register capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata);
            in_op_reg   <= s_tuser;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            latch_interval_reg <= cfg_wr_data;
        end
    end

    // State update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_level_reg <= 1'b0;
            clear_level_reg  <= 1'b0;
            last_latch_reg   <= 64'd0;
            accum_x_reg      <= 32'd0;
            accum_y_reg      <= 32'd0;
            buttons_reg      <= 8'd0;
            shifter_reg      <= 16'd0;
        end else if (proc) begin
            select_level_reg <= select_level_next;
            clear_level_reg  <= clear_level_next;
            last_latch_reg   <= last_latch_next;
            accum_x_reg      <= accum_x_next;
            accum_y_reg      <= accum_y_next;
            buttons_reg      <= buttons_next;
            shifter_reg      <= shifter_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && (in_op_reg == OP_READ)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (proc && (in_op_reg == OP_READ)) begin
            m_nibble_reg <= read_value;
        end
    end

    // A result only ever comes from an executed read.
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(proc && (in_op_reg == OP_READ)))
        else $error("result appeared without an executed read");

    // An executed read always lands in the result register.
    a_read_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && (in_op_reg == OP_READ)) |=> m_valid_reg)
        else $error("executed read did not reach the result register");

    // A line write stores the new clear level.
    a_clear_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && (in_op_reg == OP_WRITE)) |=> (clear_level_reg == $past(in_item_reg.new_clear)))
        else $error("clear level not stored on line write");

    // An empty input register always accepts.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

endmodule
